/* hw/rtl/ucs_pkg.sv */
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types, character codes and helpers for the URL component splitter.
// ----------------------------------------------------------------------------
package ucs_pkg;

   // URL delimiter characters
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;

   // Parse phase: which URL component the scanner is in
   typedef enum logic [3:0] {
      PH_SCHEME,
      PH_SLASH1,
      PH_SLASH2,
      PH_HOST,
      PH_PORT,
      PH_PATH,
      PH_QUERY,
      PH_FRAG,
      PH_BADSCH,
      PH_NOSLASH
   } phase_type;

   // Per-byte component tag
   typedef enum logic [2:0] {
      TAG_DELIM,
      TAG_SCHEME,
      TAG_HOST,
      TAG_PORT,
      TAG_PATH,
      TAG_QUERY,
      TAG_FRAG
   } tag_type;

   // End-of-URL status
   typedef enum logic [2:0] {
      ST_OK,
      ST_NO_COLON,
      ST_BAD_SCHEME,
      ST_NO_SLASHES,
      ST_HOST_NO_PATH,
      ST_PORT_NO_PATH
   } status_type;

   // Scanner state carried from one byte to the next
   typedef struct packed {
      phase_type phase;
      logic      scheme_bad;
   } scan_state_type;

   // ASCII letter test
   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   // Status reported for the phase reached on the final byte
   function automatic status_type final_status(input phase_type ph);
      status_type st;
      case (ph)
         PH_SCHEME:  st = ST_NO_COLON;
         PH_BADSCH:  st = ST_BAD_SCHEME;
         PH_SLASH1:  st = ST_NO_SLASHES;
         PH_SLASH2:  st = ST_NO_SLASHES;
         PH_NOSLASH: st = ST_NO_SLASHES;
         PH_HOST:    st = ST_HOST_NO_PATH;
         PH_PORT:    st = ST_PORT_NO_PATH;
         default:    st = ST_OK;
      endcase
      return st;
   endfunction

endpackage

/* hw/rtl/ucs_chan_if.sv */
// ----------------------------------------------------------------------------
// ucs_chan_if
// Valid/ready channels of the URL component splitter: byte in, tagged byte out.
// ----------------------------------------------------------------------------
interface ucs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_url;

   modport source (output valid, output char_in, output end_of_url, input ready);
   modport sink   (input valid, input char_in, input end_of_url, output ready);
endinterface

interface ucs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic [2:0] field_tag;
   logic       is_last;
   logic [2:0] status;

   modport source (output valid, output char_out, output field_tag, output is_last,
                   output status, input ready);
   modport sink   (input valid, input char_out, input field_tag, input is_last,
                   input status, output ready);
endinterface

/* hw/rtl/url_component_splitter_unit.sv */
// ----------------------------------------------------------------------------
// url_component_splitter_unit
// Tags each URL byte as scheme, host, port, path, query, fragment or delimiter.
// ----------------------------------------------------------------------------
// Bytes of a URL arrive on req_port with end_of_url set on the final byte; each
// one comes back on rsp_port echoed with its component tag, and the final byte
// also carries a status saying which components were complete. The unit takes
// one item every clock cycle unless the result is stalled, and returns it
// through the input register and then the result register, with the parse state
// advanced as an item moves between them. After the final byte the parser
// returns to its reset state, so URLs may follow one another without a gap.
module url_component_splitter_unit (
   input logic      clock,
   input logic      reset,
   ucs_req_if.sink   req_port,
   ucs_rsp_if.source rsp_port
);

   // Input register
   logic       s1_valid_ff;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;

   // Result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic [2:0] rsp_tag_ff;
   logic       rsp_last_ff;
   logic [2:0] rsp_status_ff;

   // Parse state
   ucs_pkg::scan_state_type state_ff;
   ucs_pkg::scan_state_type state_in;
   ucs_pkg::scan_state_type step_state;
   ucs_pkg::tag_type        step_tag;
   ucs_pkg::status_type     status_in;

   logic s2_free;
   logic advance;

   // Handshake: the result register frees when empty or drained
   assign s2_free        = !rsp_valid_ff || rsp_port.ready;
   assign advance        = s1_valid_ff && s2_free;
   assign req_port.ready = !s1_valid_ff || s2_free;

   ucs_classify u_classify (
      .cur_state  (state_ff),
      .char_byte  (s1_char_ff),
      .next_state (step_state),
      .tag        (step_tag)
   );

   // Status on the final byte, reset the parser after it
   always_comb begin
      status_in = s1_last_ff ? ucs_pkg::final_status(step_state.phase) : ucs_pkg::ST_OK;
      if (s1_last_ff) begin
         state_in.phase      = ucs_pkg::PH_SCHEME;
         state_in.scheme_bad = 1'b0;
      end else begin
         state_in = step_state;
      end
   end

   // Advance the two-stage pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         state_ff.phase      <= ucs_pkg::PH_SCHEME;
         state_ff.scheme_bad <= 1'b0;
      end else begin
         if (req_port.ready) begin
            s1_valid_ff <= req_port.valid;
         end
         if (s2_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (req_port.valid && req_port.ready) begin
         s1_char_ff <= req_port.char_in;
         s1_last_ff <= req_port.end_of_url;
      end
      if (advance) begin
         rsp_char_ff   <= s1_char_ff;
         rsp_tag_ff    <= step_tag;
         rsp_last_ff   <= s1_last_ff;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.char_out  = rsp_char_ff;
   assign rsp_port.field_tag = rsp_tag_ff;
   assign rsp_port.is_last   = rsp_last_ff;
   assign rsp_port.status    = rsp_status_ff;

   // Status is only nonzero on the final byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_status_ff == ucs_pkg::ST_OK)
      else $error("status set on a non-final item");

   // Parser is back at the scheme phase after a final byte passes
   assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> state_ff.phase == ucs_pkg::PH_SCHEME && !state_ff.scheme_bad)
      else $error("parser not reset after final item");

   // A stalled result blocks the input register from advancing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_port.ready |-> !advance)
      else $error("item advanced over a stalled result");

   // An empty input register always takes a new item
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_port.ready)
      else $error("input stalled while empty");

   // Parse state only moves when an item advances
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("parse state changed without an item");

endmodule

/* hw/rtl/ucs_classify.sv */
// ----------------------------------------------------------------------------
// ucs_classify
// Combinational byte classifier: tags one byte and computes the next state.
// ----------------------------------------------------------------------------
module ucs_classify (
   input  ucs_pkg::scan_state_type cur_state,
   input  logic [7:0]              char_byte,
   output ucs_pkg::scan_state_type next_state,
   output ucs_pkg::tag_type        tag
);

   // Walk the URL grammar one byte at a time
   always_comb begin
      next_state = cur_state;
      tag        = ucs_pkg::TAG_DELIM;
      case (cur_state.phase)
         ucs_pkg::PH_SCHEME: begin
            if (char_byte == ucs_pkg::CH_COLON) begin
               next_state.phase = cur_state.scheme_bad ? ucs_pkg::PH_BADSCH
                                                       : ucs_pkg::PH_SLASH1;
            end else begin
               if (!ucs_pkg::is_letter(char_byte)) begin
                  next_state.scheme_bad = 1'b1;
               end
               tag = ucs_pkg::TAG_SCHEME;
            end
         end
         ucs_pkg::PH_SLASH1: begin
            next_state.phase = (char_byte == ucs_pkg::CH_SLASH) ? ucs_pkg::PH_SLASH2
                                                                 : ucs_pkg::PH_NOSLASH;
         end
         ucs_pkg::PH_SLASH2: begin
            next_state.phase = (char_byte == ucs_pkg::CH_SLASH) ? ucs_pkg::PH_HOST
                                                                 : ucs_pkg::PH_NOSLASH;
         end
         ucs_pkg::PH_HOST: begin
            if (char_byte == ucs_pkg::CH_COLON) begin
               next_state.phase = ucs_pkg::PH_PORT;
            end else if (char_byte == ucs_pkg::CH_SLASH) begin
               next_state.phase = ucs_pkg::PH_PATH;
            end else begin
               tag = ucs_pkg::TAG_HOST;
            end
         end
         ucs_pkg::PH_PORT: begin
            if (char_byte == ucs_pkg::CH_SLASH) begin
               next_state.phase = ucs_pkg::PH_PATH;
            end else begin
               tag = ucs_pkg::TAG_PORT;
            end
         end
         ucs_pkg::PH_PATH: begin
            if (char_byte == ucs_pkg::CH_QMARK) begin
               next_state.phase = ucs_pkg::PH_QUERY;
            end else if (char_byte == ucs_pkg::CH_HASH) begin
               next_state.phase = ucs_pkg::PH_FRAG;
            end else begin
               tag = ucs_pkg::TAG_PATH;
            end
         end
         ucs_pkg::PH_QUERY: begin
            if (char_byte == ucs_pkg::CH_HASH) begin
               next_state.phase = ucs_pkg::PH_FRAG;
            end else begin
               tag = ucs_pkg::TAG_QUERY;
            end
         end
         ucs_pkg::PH_FRAG: begin
            tag = ucs_pkg::TAG_FRAG;
         end
         ucs_pkg::PH_BADSCH,
         ucs_pkg::PH_NOSLASH: begin
            next_state.phase = cur_state.phase;
         end
         default: begin
            next_state.phase = ucs_pkg::PH_NOSLASH;
         end
      endcase
   end

endmodule
